/* design/list_mode_event_builder_top_assert.svh */
// Assertion macros for the list-mode event builder checker.
// Needs a clk and a rst signal in the scope where a macro is used.
`ifndef LIST_MODE_EVENT_BUILDER_TOP_ASSERT_SVH
`define LIST_MODE_EVENT_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LEM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list-mode event builder check failed");

// Next-cycle implication, off during reset.
`define LEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list-mode event builder check failed");

`endif

/* design/lem_pkg.sv */
// Shared types and constants of the list-mode event builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lem_pkg;

  localparam int NUM_DET      = 4;
  localparam int ADC_BITS_DEF = 16;
  localparam int Q_BITS       = 17;   // quotient bits of the Anger divider

  // register indexes on the config port
  localparam logic [2:0] CFG_WINDOW = 3'd0;
  localparam logic [2:0] CFG_GAIN_A = 3'd1;
  localparam logic [2:0] CFG_GAIN_B = 3'd2;
  localparam logic [2:0] CFG_GAIN_C = 3'd3;
  localparam logic [2:0] CFG_GAIN_D = 3'd4;
  localparam logic [2:0] CFG_EBASE  = 3'd5;
  localparam logic [2:0] CFG_TBASE  = 3'd6;
  localparam logic [2:0] CFG_ROLL   = 3'd7;

  localparam logic [15:0] RST_WINDOW = 16'd10;
  localparam logic [15:0] RST_GAIN_A = 16'd2383;
  localparam logic [15:0] RST_GAIN_B = 16'd2384;
  localparam logic [15:0] RST_GAIN_C = 16'd2380;
  localparam logic [15:0] RST_GAIN_D = 16'd2329;
  localparam logic [11:0] RST_EBASE  = 12'd64;
  localparam logic [11:0] RST_TBASE  = 12'd80;
  localparam logic [27:0] RST_ROLL   = 28'd26;

  // word codes
  localparam logic [31:0] DATA_MASK = 32'hc000_0000;
  localparam logic [31:0] SYNC_MASK = 32'hc0f0_0000;
  localparam logic [31:0] SYNC_CODE = 32'h8040_0000;
  localparam logic [31:0] PAD_WORD  = 32'h5e5e_5e5e;
  localparam logic [31:0] PAD_ONES  = 32'hffff_ffff;
  localparam logic [6:0]  SKIP_CARD = 7'd99;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_CHECK, ST_PREP, ST_START, ST_DIVIDE, ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic check;
    logic prep;
    logic div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic is_hit;
    logic close;
    logic div_done;
  } dp_stat_t;

endpackage

/* design/lem_ctrl.sv */
// Controller FSM of the list-mode event builder.
// Depends on lem_pkg; drives the datapath commands and the handshakes.
`timescale 1ns / 1ps

module lem_ctrl import lem_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     in_ready,
  output logic     out_valid
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_next = stat.is_hit ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.close ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (stat.div_done) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* design/lem_div.sv */
// Radix-2 restoring divider for the Anger X and Y ratios, both in parallel.
// Depends on lem_pkg; one quotient bit per cycle, Q_BITS quotient bits.
`timescale 1ns / 1ps

module lem_div import lem_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [26:0]        total,
  input  logic [25:0]        mag_x,
  input  logic               neg_x,
  input  logic [25:0]        mag_y,
  input  logic               neg_y,
  output logic               done,
  output logic signed [15:0] quot_x,
  output logic signed [15:0] quot_y
);

  localparam int CW = $clog2(Q_BITS + 1);

  logic [CW-1:0]     count;
  logic [27:0]       divisor;
  logic [27:0]       rem_x, rem_y;
  logic [Q_BITS-1:0] low_x, low_y, q_x, q_y;
  logic              sign_x, sign_y;
  logic [42:0]       num_x, num_y;
  logic [28:0]       try_x, try_y;
  logic              ge_x, ge_y;

  // numerator = mag*2^16 + total; divisor = 2*total
  assign num_x = {1'b0, mag_x, 16'b0} + {16'b0, total};
  assign num_y = {1'b0, mag_y, 16'b0} + {16'b0, total};
  assign try_x = {rem_x, low_x[Q_BITS-1]};
  assign try_y = {rem_y, low_y[Q_BITS-1]};
  assign ge_x  = try_x >= {1'b0, divisor};
  assign ge_y  = try_y >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(Q_BITS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= {total, 1'b0};
      rem_x   <= {2'b0, num_x[42:Q_BITS]};
      rem_y   <= {2'b0, num_y[42:Q_BITS]};
      low_x   <= num_x[Q_BITS-1:0];
      low_y   <= num_y[Q_BITS-1:0];
      q_x     <= '0;
      q_y     <= '0;
      sign_x  <= neg_x;
      sign_y  <= neg_y;
    end else if (count != '0) begin
      rem_x <= ge_x ? 28'(try_x - {1'b0, divisor}) : try_x[27:0];
      rem_y <= ge_y ? 28'(try_y - {1'b0, divisor}) : try_y[27:0];
      low_x <= {low_x[Q_BITS-2:0], 1'b0};
      low_y <= {low_y[Q_BITS-2:0], 1'b0};
      q_x   <= {q_x[Q_BITS-2:0], ge_x};
      q_y   <= {q_y[Q_BITS-2:0], ge_y};
    end
  end

  // clamp to +32767 / -32768 and apply the sign
  function automatic logic [15:0] sat_sign(input logic [Q_BITS-1:0] q, input logic neg);
    logic [Q_BITS-1:0] s;
    s = q;
    if (!neg && s > Q_BITS'(32767)) s = Q_BITS'(32767);
    if (s > Q_BITS'(32768))         s = Q_BITS'(32768);
    return neg ? 16'(~s[15:0] + 16'd1) : s[15:0];
  endfunction

  assign done   = (count == '0);
  assign quot_x = sat_sign(q_x, sign_x);
  assign quot_y = sat_sign(q_y, sign_y);

endmodule

/* design/lem_dp.sv */
// Datapath of the list-mode event builder: config registers, timestamp
// rebuild, event store, result registers. Depends on lem_pkg and lem_div.
`timescale 1ns / 1ps

module lem_dp import lem_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [27:0]        cfg_data,
  input  logic [31:0]        ts_low_word,
  input  logic [31:0]        data_word,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [24:0]        energy_out [NUM_DET],
  output logic [63:0]        time_out   [NUM_DET],
  output logic signed [15:0] anger_x,
  output logic signed [15:0] anger_y,
  output logic [26:0]        anger_total,
  output logic               anger_valid
);

  // config
  logic [15:0] window_ticks;
  logic [15:0] gain [NUM_DET];
  logic [11:0] energy_base, time_base;
  logic [27:0] rollover_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks   <= RST_WINDOW;
      gain[0]        <= RST_GAIN_A;
      gain[1]        <= RST_GAIN_B;
      gain[2]        <= RST_GAIN_C;
      gain[3]        <= RST_GAIN_D;
      energy_base    <= RST_EBASE;
      time_base      <= RST_TBASE;
      rollover_limit <= RST_ROLL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: window_ticks   <= cfg_data[15:0];
        CFG_GAIN_A: gain[0]        <= cfg_data[15:0];
        CFG_GAIN_B: gain[1]        <= cfg_data[15:0];
        CFG_GAIN_C: gain[2]        <= cfg_data[15:0];
        CFG_GAIN_D: gain[3]        <= cfg_data[15:0];
        CFG_EBASE:  energy_base    <= cfg_data[11:0];
        CFG_TBASE:  time_base      <= cfg_data[11:0];
        CFG_ROLL:   rollover_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word
  logic [31:0] lo, dw;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo <= ts_low_word;
      dw <= data_word;
    end
  end

  // decode
  logic        is_pad, is_data, is_sync, bump;
  logic [27:0] low28;
  logic [11:0] ident;
  logic [47:0] cur_ts, hit_ts, prev_ts, ts_new;
  logic        roll_done;

  assign low28   = lo[27:0];
  assign ident   = dw[27:16];
  assign is_pad  = (lo == '0 && dw == '0) ||
                   (lo == PAD_WORD && (dw == PAD_WORD || dw == PAD_ONES));
  assign is_data = !is_pad && ((dw & DATA_MASK) == DATA_MASK) && ident[11:5] != SKIP_CARD;
  assign is_sync = !is_pad && ((dw & SYNC_MASK) == SYNC_CODE);
  assign bump    = (low28 <= rollover_limit) && !roll_done;
  assign ts_new  = {bump ? 20'(cur_ts[47:28] + 20'd1) : cur_ts[47:28], low28};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_ts    <= '0;
      roll_done <= 1'b0;
    end else if (cmd.decode) begin
      if (is_data) begin
        cur_ts <= ts_new;
        if (bump) roll_done <= 1'b1;
      end else if (is_sync) begin
        cur_ts    <= {dw[19:0], low28};
        roll_done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) hit_ts <= ts_new;
  end

  // event close and hit store
  logic        close;
  logic [47:0] gap;
  logic [11:0] e_off, t_off;
  logic        e_hit, t_hit;
  logic [1:0]  e_sel, t_sel;
  logic [31:0] prod;
  logic [32:0] prod_rnd;
  logic [15:0] adc_m;
  logic [63:0] hit_time;
  logic [24:0] ev_energy [NUM_DET];
  logic [63:0] ev_time   [NUM_DET];
  logic [NUM_DET-1:0] e_seen, t_seen, e_seen_eff, t_seen_eff;

  assign gap   = hit_ts - prev_ts;
  assign close = (hit_ts >= prev_ts) && (gap >= {32'b0, window_ticks});
  assign e_off = ident - energy_base;
  assign t_off = ident - time_base;
  assign e_hit = (ident >= energy_base) && (e_off < 12'd4);
  assign t_hit = !e_hit && (ident >= time_base) && (t_off < 12'd4);
  assign e_sel = e_off[1:0];
  assign t_sel = t_off[1:0];
  assign adc_m = 16'(dw[ADC_BITS-1:0]);
  assign prod     = adc_m * gain[e_sel];
  assign prod_rnd = {1'b0, prod} + 33'd64;
  // ts*40960 + tock*8192 + tick, and tock:tick is the whole ADC field
  assign hit_time = ({16'b0, hit_ts} << 15) + ({16'b0, hit_ts} << 13) + {48'b0, dw[15:0]};
  assign e_seen_eff = close ? '0 : e_seen;
  assign t_seen_eff = close ? '0 : t_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ts <= '0;
      e_seen  <= '0;
      t_seen  <= '0;
    end else if (cmd.check) begin
      prev_ts <= hit_ts;
      e_seen  <= e_seen_eff;
      t_seen  <= t_seen_eff;
      if (e_hit && !e_seen_eff[e_sel]) e_seen[e_sel] <= 1'b1;
      if (t_hit && !t_seen_eff[t_sel]) t_seen[t_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      if (e_hit && !e_seen_eff[e_sel]) ev_energy[e_sel] <= prod_rnd[31:7];
      if (t_hit && !t_seen_eff[t_sel]) ev_time[t_sel]   <= hit_time;
      if (close) begin
        for (int i = 0; i < NUM_DET; i++) begin
          energy_out[i] <= e_seen[i] ? ev_energy[i] : '0;
          time_out[i]   <= t_seen[i] ? ev_time[i]   : '0;
        end
      end
    end
  end

  // Anger sums
  logic [25:0] s_bd, s_ac, s_cd, s_ab;
  logic [26:0] total_r;
  logic [25:0] mag_x, mag_y;
  logic        neg_x, neg_y;

  assign s_bd = {1'b0, energy_out[1]} + {1'b0, energy_out[3]};
  assign s_ac = {1'b0, energy_out[0]} + {1'b0, energy_out[2]};
  assign s_cd = {1'b0, energy_out[2]} + {1'b0, energy_out[3]};
  assign s_ab = {1'b0, energy_out[0]} + {1'b0, energy_out[1]};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      total_r <= {1'b0, s_bd} + {1'b0, s_ac};
      neg_x   <= s_bd < s_ac;
      mag_x   <= (s_bd < s_ac) ? s_ac - s_bd : s_bd - s_ac;
      neg_y   <= s_cd < s_ab;
      mag_y   <= (s_cd < s_ab) ? s_ab - s_cd : s_cd - s_ab;
    end
  end

  logic signed [15:0] q_x, q_y;
  logic               div_done;

  lem_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .total  (total_r),
    .mag_x  (mag_x),
    .neg_x  (neg_x),
    .mag_y  (mag_y),
    .neg_y  (neg_y),
    .done   (div_done),
    .quot_x (q_x),
    .quot_y (q_y)
  );

  assign anger_total = total_r;
  assign anger_valid = total_r != '0;
  assign anger_x     = anger_valid ? q_x : '0;
  assign anger_y     = anger_valid ? q_y : '0;

  assign stat.is_hit   = is_data;
  assign stat.close    = close;
  assign stat.div_done = div_done;

endmodule

/* design/list_mode_event_builder_top.sv */
// Top level of the list-mode event builder with Anger logic.
// Depends on lem_pkg, lem_ctrl and lem_dp.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------
//  s_axis    | in  | tvalid / tready    | tdata: list-mode word (64 bits)
//  m_axis    | out | tvalid / tready    | tdata: event (416), tuser: valid
//  cfg       | in  | cfg_we             | cfg_index, cfg_data (28 bits)
//
// One word at a time. Padding, sync and skipped words go from accept through
// decode back to ready; a hit that opens no new event also passes the check.
// A hit that closes an event adds the prep and start states and the
// bit-serial Anger divider (17 quotient bits, until its done flag), then
// offers the event until m_axis_tready.
// s_axis_tready is low while an event waits on m_axis.
// rst is synchronous, active high; it restores the register defaults and
// clears the timestamp and event state.
`timescale 1ns / 1ps

module list_mode_event_builder_top import lem_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // ts_low_word[31:0], data_word[63:32]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // energy_a..d [99:0] (25 each), time_a..d [355:100] (64 each),
  // anger_x [371:356], anger_y [387:372], anger_total [414:388], zero [415]
  output logic [415:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser,   // anger_valid[0]
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [27:0]  cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [24:0]        energy [NUM_DET];
  logic [63:0]        hit_tm [NUM_DET];
  logic signed [15:0] anger_x, anger_y;
  logic [26:0]        anger_total;
  logic               anger_valid;

  // sequencer: one beat in, work through decode / check / divide, one beat out
  lem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  lem_dp #(.ADC_BITS(ADC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ts_low_word (s_axis_tdata[31:0]),
    .data_word   (s_axis_tdata[63:32]),
    .cmd         (cmd),
    .stat        (stat),
    .energy_out  (energy),
    .time_out    (hit_tm),
    .anger_x     (anger_x),
    .anger_y     (anger_y),
    .anger_total (anger_total),
    .anger_valid (anger_valid)
  );

  // result beat; all fields come from registers held until the beat is taken
  assign m_axis_tdata = {1'b0, anger_total, anger_y, anger_x,
                         hit_tm[3], hit_tm[2], hit_tm[1], hit_tm[0],
                         energy[3], energy[2], energy[1], energy[0]};
  assign m_axis_tuser = anger_valid;

endmodule

/* design/lem_checker.sv */
// Port-level checker for the list-mode event builder, bound to the top.
// Depends on list_mode_event_builder_top_assert.svh for the macros.
`timescale 1ns / 1ps
`include "list_mode_event_builder_top_assert.svh"

module lem_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [415:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // a stalled event stays offered
  `LEM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // the input side is closed while an event waits
  `LEM_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready)
  // an accepted word leaves the block busy in the next cycle
  `LEM_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // anger_valid tracks a nonzero total
  `LEM_ASSERT_NOW(a_valid_total, m_axis_tvalid,
                  m_axis_tuser[0] == (m_axis_tdata[414:388] != 27'd0))

endmodule

bind list_mode_event_builder_top lem_checker u_lem_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
